>>> rtl/core/mfva_pkg.sv
// Shared types, codes and constant tables for the MIDI FM voice allocator.
// No dependencies; imported by mfva_voice_table and midi_fm_voice_allocator_top.
package mfva_pkg;

  // Result register targets
  typedef enum logic [1:0] {
    TGT_ATTR0 = 2'd0,
    TGT_WAVE  = 2'd1,
    TGT_CHAN  = 2'd2,
    TGT_KEYON = 2'd3
  } target_e;

  // MIDI status high nibble
  localparam logic [3:0] CMD_NOTE_OFF = 4'd8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'd9;
  localparam logic [3:0] CMD_CTRL     = 4'd11;
  localparam logic [3:0] CMD_PROGRAM  = 4'd12;
  localparam logic [3:0] CMD_SYSTEM   = 4'd15;

  localparam logic [3:0] CHAN_SYS_RESET = 4'hF;
  localparam logic [7:0] CTRL_SOUND_OFF = 8'd120;
  localparam logic [7:0] CTRL_NOTES_OFF = 8'd123;
  localparam logic [7:0] DATA_MAX       = 8'd127;
  localparam logic [7:0] PROGRAM_MAX    = 8'd3;
  localparam logic [6:0] AGE_MAX        = 7'd127;
  localparam logic [6:0] NOTE_MIN       = 7'd12;
  localparam logic [6:0] FNUM_COUNT     = 7'd19;

  // Voice table operations
  typedef enum logic [2:0] {
    VT_NOP       = 3'd0,
    VT_RELEASE   = 3'd1,
    VT_AGE       = 3'd2,
    VT_CLAIM     = 3'd3,
    VT_KILL      = 3'd4,
    VT_CLEAR_ALL = 3'd5
  } vt_op_e;

  typedef struct packed {
    vt_op_e     op;
    logic [3:0] chan;
    logic [6:0] note;
  } vt_req_t;

  typedef struct packed {
    logic       owned;    // valid and owned by the requested channel
    logic       note_eq;  // stored note equals the requested note
    logic       free;
    logic [6:0] age;
  } vt_stat_t;

  function automatic logic [9:0] fnum_rom(input logic [4:0] idx);
    logic [9:0] f;
    unique case (idx)
      5'd0:    f = 10'd346;
      5'd1:    f = 10'd367;
      5'd2:    f = 10'd389;
      5'd3:    f = 10'd412;
      5'd4:    f = 10'd436;
      5'd5:    f = 10'd462;
      5'd6:    f = 10'd490;
      5'd7:    f = 10'd519;
      5'd8:    f = 10'd550;
      5'd9:    f = 10'd582;
      5'd10:   f = 10'd617;
      5'd11:   f = 10'd654;
      5'd12:   f = 10'd692;
      5'd13:   f = 10'd733;
      5'd14:   f = 10'd777;
      5'd15:   f = 10'd823;
      5'd16:   f = 10'd872;
      5'd17:   f = 10'd924;
      5'd18:   f = 10'd979;
      default: f = 10'd0;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] instr_attr0(input logic [1:0] sel, input logic op);
    logic [31:0] w;
    unique case (sel)
      2'd0:    w = op ? 32'hE10E5005 : 32'h6117F000;
      2'd1:    w = op ? 32'h4040F0F7 : 32'h400DF1F7;
      2'd2:    w = op ? 32'h0000F7FF : 32'h0200FB58;
      default: w = op ? 32'h013FF0F7 : 32'h0100F0F7;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] instr_wave(input logic [1:0] sel, input logic op);
    return (sel == 2'd1 && op) ? 32'd6 : 32'd0;
  endfunction

  function automatic logic [31:0] instr_chan(input logic [1:0] sel);
    logic [31:0] w;
    unique case (sel)
      2'd0:    w = 32'h00380000;
      2'd1:    w = 32'h003C0000;
      2'd2:    w = 32'h003E0000;
      default: w = 32'h003F0000;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/mfva_voice_table.sv
// Per-voice owner, note and age storage with a single indexed access port.
// Depends on mfva_pkg.
module mfva_voice_table #(
  parameter int NUM_VOICES = 32,
  localparam int VW = $clog2(NUM_VOICES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfva_pkg::vt_req_t  req_i,
  input  logic [VW-1:0]      idx_i,
  output mfva_pkg::vt_stat_t stat_o
);
  import mfva_pkg::*;

  logic [NUM_VOICES-1:0] valid_q;
  logic [3:0]            chan_q [NUM_VOICES];
  logic [6:0]            note_q [NUM_VOICES];
  logic [6:0]            age_q  [NUM_VOICES];

  assign stat_o.owned   = valid_q[idx_i] && (chan_q[idx_i] == req_i.chan);
  assign stat_o.note_eq = (note_q[idx_i] == req_i.note);
  assign stat_o.free    = !valid_q[idx_i];
  assign stat_o.age     = age_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      unique case (req_i.op)
        VT_RELEASE: begin
          valid_q[idx_i] <= 1'b0;
          age_q[idx_i]   <= '0;
        end
        VT_AGE: begin
          if (!valid_q[idx_i] && age_q[idx_i] != AGE_MAX) begin
            age_q[idx_i] <= age_q[idx_i] + 7'd1;
          end
        end
        VT_CLAIM:     valid_q[idx_i] <= 1'b1;
        VT_KILL: begin
          if (stat_o.owned) begin
            valid_q[idx_i] <= 1'b0;
          end
        end
        VT_CLEAR_ALL: valid_q <= '0;
        default: ;
      endcase
    end
  end

  // owner channel and note only matter while the entry is valid
  always_ff @(posedge clk_i) begin
    if (req_i.op == VT_CLAIM) begin
      chan_q[idx_i] <= req_i.chan;
      note_q[idx_i] <= req_i.note;
    end
  end

`ifndef SYNTHESIS
  a_claim_owns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.op == VT_CLAIM |=>
      valid_q[$past(idx_i)] && chan_q[$past(idx_i)] == $past(req_i.chan)
      && note_q[$past(idx_i)] == $past(req_i.note))
    else $error("claimed voice not owned by requester");

  a_release_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.op == VT_RELEASE |=> !valid_q[$past(idx_i)] && age_q[$past(idx_i)] == '0)
    else $error("released voice still valid or aged");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.op == VT_CLEAR_ALL |=> valid_q == '0)
    else $error("voice still valid after clear");
`endif

endmodule

>>> rtl/core/midi_fm_voice_allocator_top.sv
// MIDI FM voice allocator: sequencer, key-on mask, instrument select, result register.
// Depends on mfva_pkg and mfva_voice_table.
//
// One message at a time; s_axis_tready_o is high only when idle.
// A voice-table scan walks one voice per cycle through the shared compare port.
// Note off: a release scan over the voices, aging of the free voices, one mask transfer.
// Note on: release as above, then an allocation scan, claim, six transfers.
// Async active-low reset frees every voice, clears ages, key-on mask and instrument.
module midi_fm_voice_allocator_top #(
  parameter int NUM_VOICES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [3:0] channel, [11:4] key_or_control, [19:12] level
  input  logic [3:0]  s_axis_tuser_i,   // [3:0] cmd
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [5:0] index, [37:6] write_data
  output logic [1:0]  m_axis_tuser_o,   // [1:0] target
  output logic        m_axis_tlast_o    // last write of this message
);
  import mfva_pkg::*;

  localparam int VW = $clog2(NUM_VOICES);
  localparam logic [VW-1:0] LastVoice = VW'(NUM_VOICES - 1);
  localparam logic [2:0] STEP_CHAN  = 3'd4;
  localparam logic [2:0] STEP_KEYON = 3'd5;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_REL_SCAN   = 8'b0000_0010,  // find first voice playing chan/note
    S_AGE        = 8'b0000_0100,  // age every free voice
    S_MASK       = 8'b0000_1000,  // key-on mask transfer
    S_ALLOC_SCAN = 8'b0001_0000,  // oldest free voice
    S_CLAIM      = 8'b0010_0000,
    S_NOTE_EMIT  = 8'b0100_0000,  // six writes of a note on
    S_AOFF_SCAN  = 8'b1000_0000   // all notes off for a channel
  } state_e;

  state_e state_q, state_d;

  // message fields held for the whole sequence
  logic [3:0] chan_q, chan_d;
  logic [6:0] key_q, key_d;
  logic       vel_zero_q, vel_zero_d;
  logic       on_note_q, on_note_d;

  // scan bookkeeping
  logic [VW-1:0] scan_q, scan_d;
  logic [VW-1:0] pick_q, pick_d;
  logic [6:0]    best_q, best_d;
  logic          found_q, found_d;
  logic          any_q, any_d;
  logic [2:0]    step_q, step_d;

  logic [NUM_VOICES-1:0] mask_q, mask_d;
  logic [1:0]            instr_q, instr_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_target_q;
  logic [5:0]  out_index_q;
  logic [31:0] out_data_q;
  logic        out_last_q;

  logic        emit;
  logic [1:0]  emit_target;
  logic [5:0]  emit_index;
  logic [31:0] emit_data;
  logic        emit_last;
  logic        can_load;

  vt_req_t  vt_req;
  vt_stat_t vt_stat;
  logic [VW-1:0] vt_idx;

  mfva_voice_table #(
    .NUM_VOICES(NUM_VOICES)
  ) u_voice_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (vt_req),
    .idx_i  (vt_idx),
    .stat_o (vt_stat)
  );

  // ---------------------------------------------------------------------------
  // Note decode: block and fnum index. note/12 by reciprocal (171/2048), exact
  // for 7-bit notes; quotient registered before the rest of the decode.
  // ---------------------------------------------------------------------------
  logic [14:0] q_prod;
  logic [3:0]  q_q;
  logic [2:0]  blk;
  logic [6:0]  blk_p1;
  logic [6:0]  base;
  logic [6:0]  fidx;
  logic        note_ok;
  logic        cont;

  assign q_prod = 15'(key_q) * 15'd171;

  always_ff @(posedge clk_i) begin
    q_q <= q_prod[14:11];
  end

  assign blk     = (q_q > 4'd8) ? 3'd7 : 3'(q_q - 4'd1);
  assign blk_p1  = {4'd0, blk} + 7'd1;
  assign base    = (blk_p1 << 3) + (blk_p1 << 2);
  assign fidx    = key_q - base;
  assign note_ok = (key_q >= NOTE_MIN) && (fidx < FNUM_COUNT);
  // a note on goes on to allocate after its release part
  assign cont    = on_note_q && !vel_zero_q && note_ok;

  logic [5:0]  pick6;
  logic [31:0] mask_ext;

  always_comb begin
    pick6 = '0;
    pick6[VW-1:0] = pick_q;
    mask_ext = '0;
    mask_ext[NUM_VOICES-1:0] = mask_q;
  end

  assign can_load = !out_valid_q || m_axis_tready_i;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic       cand;
  logic [7:0] in_key;
  logic [7:0] in_lvl;

  assign in_key = s_axis_tdata_i[11:4];
  assign in_lvl = s_axis_tdata_i[19:12];
  assign cand   = vt_stat.free && (!found_q || vt_stat.age > best_q);
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    chan_d     = chan_q;
    key_d      = key_q;
    vel_zero_d = vel_zero_q;
    on_note_d  = on_note_q;
    scan_d     = scan_q;
    pick_d     = pick_q;
    best_d     = best_q;
    found_d    = found_q;
    any_d      = any_q;
    step_d     = step_q;
    mask_d     = mask_q;
    instr_d    = instr_q;

    vt_req.op   = VT_NOP;
    vt_req.chan = chan_q;
    vt_req.note = key_q;
    vt_idx      = scan_q;

    emit        = 1'b0;
    emit_target = TGT_KEYON;
    emit_index  = '0;
    emit_data   = mask_ext;
    emit_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          chan_d     = s_axis_tdata_i[3:0];
          key_d      = in_key[6:0];
          vel_zero_d = (in_lvl == 8'd0);
          on_note_d  = 1'b0;
          scan_d     = '0;
          found_d    = 1'b0;
          any_d      = 1'b0;
          unique case (s_axis_tuser_i)
            CMD_NOTE_OFF: begin
              if (in_key <= DATA_MAX) state_d = S_REL_SCAN;
            end
            CMD_NOTE_ON: begin
              if (in_key <= DATA_MAX) begin
                on_note_d = 1'b1;
                state_d   = S_REL_SCAN;
              end
            end
            CMD_CTRL: begin
              if (in_key <= DATA_MAX && in_lvl <= DATA_MAX
                  && (in_key == CTRL_SOUND_OFF || in_key == CTRL_NOTES_OFF)) begin
                state_d = S_AOFF_SCAN;
              end
            end
            CMD_PROGRAM: begin
              if (in_key <= PROGRAM_MAX) instr_d = in_key[1:0];
            end
            CMD_SYSTEM: begin
              if (s_axis_tdata_i[3:0] == CHAN_SYS_RESET) begin
                vt_req.op = VT_CLEAR_ALL;
                mask_d    = '0;
                state_d   = S_MASK;
              end
            end
            default: ;
          endcase
        end
      end

      S_REL_SCAN: begin
        if (vt_stat.owned && vt_stat.note_eq) begin
          vt_req.op      = VT_RELEASE;
          mask_d[scan_q] = 1'b0;
          scan_d         = '0;
          state_d        = S_AGE;
        end else if (scan_q == LastVoice) begin
          scan_d  = '0;
          found_d = 1'b0;
          state_d = cont ? S_ALLOC_SCAN : S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_AGE: begin
        vt_req.op = VT_AGE;
        if (scan_q == LastVoice) begin
          state_d = S_MASK;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_MASK: begin
        if (can_load) begin
          emit      = 1'b1;
          emit_last = !cont;
          scan_d    = '0;
          found_d   = 1'b0;
          state_d   = cont ? S_ALLOC_SCAN : S_IDLE;
        end
      end

      S_ALLOC_SCAN: begin
        if (cand) begin
          found_d = 1'b1;
          best_d  = vt_stat.age;
          pick_d  = scan_q;
        end
        if (scan_q == LastVoice) begin
          state_d = (found_q || cand) ? S_CLAIM : S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_CLAIM: begin
        vt_req.op      = VT_CLAIM;
        vt_idx         = pick_q;
        mask_d[pick_q] = 1'b1;
        step_d         = '0;
        state_d        = S_NOTE_EMIT;
      end

      S_NOTE_EMIT: begin
        // operator writes for op0 then op1, channel word, key-on mask
        priority if (step_q == STEP_KEYON) begin
          emit_last = 1'b1;
        end else if (step_q == STEP_CHAN) begin
          emit_target = TGT_CHAN;
          emit_index  = pick6;
          emit_data   = instr_chan(instr_q) | {19'd0, blk, fnum_rom(fidx[4:0])};
        end else begin
          emit_target = step_q[0] ? TGT_WAVE : TGT_ATTR0;
          emit_index  = {pick6[4:0], step_q[1]};
          emit_data   = step_q[0] ? instr_wave(instr_q, step_q[1])
                                  : instr_attr0(instr_q, step_q[1]);
        end
        if (can_load) begin
          emit   = 1'b1;
          step_d = step_q + 3'd1;
          if (step_q == STEP_KEYON) state_d = S_IDLE;
        end
      end

      S_AOFF_SCAN: begin
        if (vt_stat.owned) begin
          vt_req.op      = VT_KILL;
          mask_d[scan_q] = 1'b0;
          any_d          = 1'b1;
        end
        if (scan_q == LastVoice) begin
          state_d = (any_q || vt_stat.owned) ? S_MASK : S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit && can_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= '0;
      instr_q     <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      on_note_q   <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      instr_q     <= instr_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      found_q     <= found_d;
      any_q       <= any_d;
      on_note_q   <= on_note_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q     <= chan_d;
    key_q      <= key_d;
    vel_zero_q <= vel_zero_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
    if (emit && can_load) begin
      out_target_q <= emit_target;
      out_index_q  <= emit_index;
      out_data_q   <= emit_data;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_target_q;
  assign m_axis_tdata_o  = {2'b00, out_data_q, out_index_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_claim_sets_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLAIM |=> mask_q[$past(pick_q)])
    else $error("claimed voice missing from key-on mask");

  a_emit_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_load)
    else $error("result produced with output register full");

  a_last_ends_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_last |=> state_q == S_IDLE)
    else $error("sequencer busy after last transfer");
`endif

endmodule

>>> verif/tb_midi_fm_voice_allocator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for midi_fm_voice_allocator_top: directed opening script, then random
// MIDI traffic checked against an in-bench voice pool model. Depends on mfva_pkg and the RTL.
module tb_midi_fm_voice_allocator_top;
  import mfva_pkg::*;

  localparam int NV          = 32;
  localparam int STALL_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int DRAIN       = 200;   // quiet cycles after the last write

  // Status nibble the block should ignore; used as noise
  localparam logic [3:0] CMD_UNUSED   = 4'h0;
  localparam logic [7:0] CTRL_VOLUME  = 8'd7;

  // Instrument ROM, packed low entry first: attr words at (patch*2+op)*32, chan words at patch*32
  localparam logic [255:0] PATCH_OP_ATTR = {
    32'h013FF0F7, 32'h0100F0F7, 32'h0000F7FF, 32'h0200FB58,
    32'h4040F0F7, 32'h400DF1F7, 32'hE10E5005, 32'h6117F000};
  localparam logic [127:0] PATCH_CHAN = {
    32'h003F0000, 32'h003E0000, 32'h003C0000, 32'h00380000};
  localparam logic [31:0] WAVE_ALT = 32'd6;  // op1 waveform of patch 1, all others 0
  // Frequency numbers for the 19 notes of one block, index 0 in the low bits
  localparam logic [189:0] FNUM_TAB = {
    10'd979, 10'd924, 10'd872, 10'd823, 10'd777, 10'd733, 10'd692, 10'd654, 10'd617, 10'd582,
    10'd550, 10'd519, 10'd490, 10'd462, 10'd436, 10'd412, 10'd389, 10'd367, 10'd346};

  // One synthesizer register write
  typedef struct {
    target_e     target;
    logic [5:0]  index;
    logic [31:0] data;
    logic        last;
  } reg_write_t;

  // How an opening-script row is checked
  typedef enum { ROW_PREDICT, ROW_SILENT, ROW_KEYON } row_kind_e;

  typedef struct {
    logic [3:0]  cmd;
    logic [3:0]  ch;
    logic [7:0]  key;
    logic [7:0]  lvl;
    row_kind_e   kind;
    logic [31:0] keyon_word;  // only for ROW_KEYON
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Voice pool model
  bit          voice_busy [NV];
  logic [3:0]  voice_chan [NV];
  logic [6:0]  voice_key  [NV];
  logic [6:0]  voice_age  [NV];
  logic [31:0] keyon_bits;
  logic [1:0]  patch_sel;

  reg_write_t  msg_writes[$];      // writes of the message being modeled
  reg_write_t  pending_writes[$];  // writes still owed by the block, oldest first
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;        // both sides stop idling while set

  script_row_t opening_script [25] = '{
    // nothing is held after reset, so note off is silent
    '{CMD_NOTE_OFF, 4'd0,           8'd60,          8'd64,  ROW_SILENT,  32'd0},
    '{CMD_SYSTEM,   CHAN_SYS_RESET, 8'd0,           8'd0,   ROW_KEYON,   32'd0},
    '{CMD_SYSTEM,   4'd14,          8'd0,           8'd0,   ROW_SILENT,  32'd0},
    // lowest and highest playable notes
    '{CMD_NOTE_ON,  4'd0,           8'd12,          8'd127, ROW_PREDICT, 32'd0},
    '{CMD_NOTE_ON,  4'd15,          8'd114,         8'd1,   ROW_PREDICT, 32'd0},
    // out of the fnum range, below block 0, data byte above 127
    '{CMD_NOTE_ON,  4'd3,           8'd115,         8'd100, ROW_SILENT,  32'd0},
    '{CMD_NOTE_ON,  4'd3,           8'd11,          8'd100, ROW_SILENT,  32'd0},
    '{CMD_NOTE_ON,  4'd3,           8'd200,         8'd100, ROW_SILENT,  32'd0},
    '{CMD_PROGRAM,  4'd0,           8'd1,           8'd0,   ROW_SILENT,  32'd0},
    '{CMD_NOTE_ON,  4'd2,           8'd69,          8'd255, ROW_PREDICT, 32'd0},
    // retrigger, then velocity-zero note off
    '{CMD_NOTE_ON,  4'd0,           8'd12,          8'd90,  ROW_PREDICT, 32'd0},
    '{CMD_NOTE_ON,  4'd0,           8'd12,          8'd0,   ROW_PREDICT, 32'd0},
    '{CMD_NOTE_OFF, 4'd15,          8'd114,         8'd0,   ROW_PREDICT, 32'd0},
    '{CMD_PROGRAM,  4'd9,           8'd3,           8'd0,   ROW_SILENT,  32'd0},
    '{CMD_NOTE_ON,  4'd5,           8'd60,          8'd64,  ROW_PREDICT, 32'd0},
    '{CMD_PROGRAM,  4'd5,           8'd200,         8'd0,   ROW_SILENT,  32'd0},
    '{CMD_PROGRAM,  4'd5,           8'd2,           8'd0,   ROW_SILENT,  32'd0},
    '{CMD_NOTE_ON,  4'd5,           8'd61,          8'd64,  ROW_PREDICT, 32'd0},
    // controller value or number above 127, an unhandled controller
    '{CMD_CTRL,     4'd5,           CTRL_NOTES_OFF, 8'd200, ROW_SILENT,  32'd0},
    '{CMD_CTRL,     4'd5,           8'd255,         8'd0,   ROW_SILENT,  32'd0},
    '{CMD_CTRL,     4'd5,           CTRL_VOLUME,    8'd100, ROW_SILENT,  32'd0},
    // all sound off frees both ch5 voices; the all-notes-off after it finds nothing
    '{CMD_CTRL,     4'd5,           CTRL_SOUND_OFF, 8'd0,   ROW_PREDICT, 32'd0},
    '{CMD_CTRL,     4'd5,           CTRL_NOTES_OFF, 8'd0,   ROW_SILENT,  32'd0},
    '{CMD_UNUSED,   4'd0,           8'd255,         8'd255, ROW_SILENT,  32'd0},
    '{CMD_NOTE_OFF, 4'd2,           8'd255,         8'd0,   ROW_SILENT,  32'd0}
  };

  midi_fm_voice_allocator_top #(
    .NUM_VOICES(NV)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Voice pool model
  // ---------------------------------------------------------------------------
  function automatic void add_write(input target_e tgt, input int idx, input logic [31:0] d);
    reg_write_t w;
    w.target = tgt;
    w.index  = idx[5:0];
    w.data   = d;
    w.last   = 1'b0;
    msg_writes.push_back(w);
  endfunction

  // First voice of this channel playing this note is freed; free voices then age by one.
  function automatic void free_note(input logic [3:0] ch, input logic [6:0] key);
    int hit;
    hit = -1;
    for (int v = 0; v < NV; v++)
      if (hit < 0 && voice_busy[v] && voice_chan[v] == ch && voice_key[v] == key) hit = v;
    if (hit < 0) return;
    keyon_bits[hit] = 1'b0;
    voice_busy[hit] = 1'b0;
    voice_age[hit]  = '0;
    for (int v = 0; v < NV; v++)
      if (!voice_busy[v] && voice_age[v] < AGE_MAX) voice_age[v]++;
    add_write(TGT_KEYON, 0, keyon_bits);
  endfunction

  function automatic void play_note(input logic [3:0] ch, input logic [7:0] key,
                                    input logic [7:0] vel);
    int blk, step, pick, best;
    free_note(ch, key[6:0]);  // retrigger releases first
    if (vel == 0 || key < NOTE_MIN) return;
    blk = key / 12 - 1;
    if (blk > 7) blk = 7;
    step = key - (blk + 1) * 12;
    if (step >= FNUM_COUNT) return;
    // oldest free voice, lowest index on a tie
    pick = -1;
    best = -1;
    for (int v = 0; v < NV; v++)
      if (!voice_busy[v] && int'(voice_age[v]) > best) begin
        best = int'(voice_age[v]);
        pick = v;
      end
    if (pick < 0) return;  // pool exhausted
    voice_busy[pick] = 1'b1;
    voice_chan[pick] = ch;
    voice_key[pick]  = key[6:0];
    for (int op = 0; op < 2; op++) begin
      add_write(TGT_ATTR0, pick * 2 + op, PATCH_OP_ATTR[(patch_sel * 2 + op) * 32 +: 32]);
      add_write(TGT_WAVE, pick * 2 + op, (patch_sel == 2'd1 && op == 1) ? WAVE_ALT : 32'd0);
    end
    add_write(TGT_CHAN, pick,
              PATCH_CHAN[patch_sel * 32 +: 32] | (32'(blk) << 10) | 32'(FNUM_TAB[step * 10 +: 10]));
    keyon_bits[pick] = 1'b1;
    add_write(TGT_KEYON, 0, keyon_bits);
  endfunction

  // Updates the pool for one message and leaves its writes in msg_writes.
  function automatic void model_message(input logic [3:0] cmd, input logic [3:0] ch,
                                        input logic [7:0] key, input logic [7:0] lvl);
    bit any;
    msg_writes.delete();
    any = 1'b0;
    case (cmd)
      CMD_NOTE_OFF: if (key <= DATA_MAX) free_note(ch, key[6:0]);
      CMD_NOTE_ON:  if (key <= DATA_MAX) play_note(ch, key, lvl);
      CMD_CTRL: begin
        if (key <= DATA_MAX && lvl <= DATA_MAX &&
            (key == CTRL_SOUND_OFF || key == CTRL_NOTES_OFF)) begin
          // ages are left alone here
          for (int v = 0; v < NV; v++)
            if (voice_busy[v] && voice_chan[v] == ch) begin
              keyon_bits[v] = 1'b0;
              voice_busy[v] = 1'b0;
              any = 1'b1;
            end
          if (any) add_write(TGT_KEYON, 0, keyon_bits);
        end
      end
      CMD_PROGRAM: if (key <= PROGRAM_MAX) patch_sel = key[1:0];
      CMD_SYSTEM: begin
        if (ch == CHAN_SYS_RESET) begin
          keyon_bits = '0;
          for (int v = 0; v < NV; v++) voice_busy[v] = 1'b0;
          add_write(TGT_KEYON, 0, 32'd0);
        end
      end
      default: ;
    endcase
    if (msg_writes.size() > 0) msg_writes[msg_writes.size() - 1].last = 1'b1;
  endfunction

  // Random held voice, or -1 when the pool is empty
  function automatic int held_voice();
    int start;
    start = $urandom_range(NV - 1);
    for (int k = 0; k < NV; k++)
      if (voice_busy[(start + k) % NV]) return (start + k) % NV;
    return -1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one message per call; tvalid stays high into the next call
  // unless that call starts with an idle gap.
  // ---------------------------------------------------------------------------
  task automatic send_msg(input logic [3:0] cmd, input logic [3:0] ch, input logic [7:0] key,
                          input logic [7:0] lvl, input row_kind_e kind,
                          input logic [31:0] keyon_word);
    reg_write_t w;
    while (!calm && $urandom_range(99) < 22) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {4'd0, lvl, key, ch};
    s_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // transfer taken at this edge
    model_message(cmd, ch, key, lvl);
    case (kind)
      ROW_PREDICT: foreach (msg_writes[i]) pending_writes.push_back(msg_writes[i]);
      ROW_KEYON: begin
        w.target = TGT_KEYON;
        w.index  = '0;
        w.data   = keyon_word;
        w.last   = 1'b1;
        pending_writes.push_back(w);
      end
      default: ;  // ROW_SILENT owes nothing
    endcase
  endtask

  // Random message; filling leans on note on so the pool runs full.
  task automatic send_random(input bit filling);
    int r, v;
    logic [3:0] ch;
    logic [7:0] key, lvl;
    r   = $urandom_range(99);
    v   = held_voice();
    ch  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    key = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(114, 12));
    lvl = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
    if (filling ? r < 70 : r < 40)
      send_msg(CMD_NOTE_ON, ch, key, lvl, ROW_PREDICT, 0);
    else if ((filling ? r < 85 : r < 65) && v >= 0)
      send_msg(CMD_NOTE_OFF, voice_chan[v], {1'b0, voice_key[v]}, 8'($urandom_range(255)),
               ROW_PREDICT, 0);
    else if (filling ? r < 85 : r < 70)
      send_msg(CMD_NOTE_OFF, ch, key, lvl, ROW_PREDICT, 0);
    else if (filling ? r < 90 : r < 76) begin
      // mostly well-formed all-notes-off aimed at a playing channel
      if (v >= 0 && $urandom_range(3) != 0) ch = voice_chan[v];
      case ($urandom_range(5))
        0, 1:    key = CTRL_SOUND_OFF;
        2, 3:    key = CTRL_NOTES_OFF;
        default: key = 8'($urandom_range(255));
      endcase
      lvl = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
      send_msg(CMD_CTRL, ch, key, lvl, ROW_PREDICT, 0);
    end else if (filling ? r < 95 : r < 82)
      send_msg(CMD_PROGRAM, ch,
               ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4)),
               8'($urandom_range(255)), ROW_PREDICT, 0);
    else if (!filling && r < 86)
      send_msg(CMD_SYSTEM, 4'($urandom_range(15, 12)), 8'($urandom_range(255)),
               8'($urandom_range(255)), ROW_PREDICT, 0);
    else
      // noise: any status nibble, any data
      send_msg(4'($urandom_range(15)), 4'($urandom_range(15)), 8'($urandom_range(255)),
               8'($urandom_range(255)), ROW_PREDICT, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns mismatch %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    reg_write_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("write with nothing owed", m_axis_tdata_o[37:6], 32'd0);
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tuser_o != want.target)
          report_mismatch("target", 32'(m_axis_tuser_o), 32'(want.target));
        if (m_axis_tdata_o[5:0] != want.index)
          report_mismatch("index", 32'(m_axis_tdata_o[5:0]), 32'(want.index));
        if (m_axis_tdata_o[37:6] != want.data)
          report_mismatch("write_data", m_axis_tdata_o[37:6], want.data);
        if (m_axis_tlast_o != want.last)
          report_mismatch("tlast", 32'(m_axis_tlast_o), 32'(want.last));
      end
    end
    m_ready <= calm || ($urandom_range(99) >= 22);
  end

  // Watchdog: too long without a transfer on either stream
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int v = 0; v < NV; v++) begin
      voice_busy[v] = 1'b0;
      voice_chan[v] = '0;
      voice_key[v]  = '0;
      voice_age[v]  = '0;
    end
    keyon_bits = '0;
    patch_sel  = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // opening script: edge cases, every command
    foreach (opening_script[i])
      send_msg(opening_script[i].cmd, opening_script[i].ch, opening_script[i].key,
               opening_script[i].lvl, opening_script[i].kind, opening_script[i].keyon_word);

    // fill the pool past exhaustion; the back half runs without idling
    for (int n = 0; n < 90; n++) begin
      calm = (n >= 45);
      send_random(1'b1);
    end
    calm = 1'b0;

    // hold off until the block has delivered everything owed
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_writes.size() != 0);

    for (int n = 0; n < 115; n++) send_random(1'b0);

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_writes.size() != 0);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
